FILE: rtl/core/hmac_pkg.sv
// ----------------------------------------------------------------------------
// hmac_pkg
// Shared types, codes and SHA-256 round functions for the HMAC-SHA256 engine.
// ----------------------------------------------------------------------------
package hmac_pkg;

  // Request codes on the input channel
  localparam logic [1:0] REQ_KEY = 2'd0;
  localparam logic [1:0] REQ_MSG = 2'd1;
  localparam logic [1:0] REQ_FIN = 2'd2;

  // Pad bytes
  localparam logic [7:0] IPAD     = 8'h36;
  localparam logic [7:0] OPAD     = 8'h5c;
  localparam logic [7:0] NOPAD    = 8'h00;
  localparam logic [7:0] PAD_MARK = 8'h80;

  // SHA-256 initial hash value, word 0 in the top bits
  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_KEYLD, S_WRBYTE, S_PAD, S_LEN, S_HASH, S_DIGKEY, S_DIGBLK, S_OUT
  } st_e;

  // Transaction phase
  typedef enum logic [2:0] {
    PH_IDLE, PH_KEY, PH_LONG, PH_HMAC, PH_PLAIN
  } ph_e;

  // Step that follows a block compression
  typedef enum logic [2:0] {
    A_IDLE, A_WRBYTE, A_PAD, A_FINAL, A_REQ, A_DIGBLK
  } aft_e;

  // What a finished digest is used for
  typedef enum logic [1:0] {
    F_LONGKEY, F_INNER, F_DONE
  } fin_e;

  // Compression core states
  typedef enum logic [1:0] {
    C_IDLE, C_LOAD, C_ROUND, C_UPD
  } cst_e;

  // Block buffer write port
  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [3:0]  be;
    logic [31:0] data;
  } blk_wr_t;

  // Core control and status
  typedef struct packed {
    logic start;
    logic last_blk;
    logic init;
  } hs_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hs_sts_t;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Round constants
  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    round_k = k;
  endfunction

endpackage

FILE: rtl/core/hmac_sha256_engine.sv
// ----------------------------------------------------------------------------
// hmac_sha256_engine
// Streaming HMAC-SHA256 / SHA-256 engine, one key or message byte per item.
// ----------------------------------------------------------------------------
// Usage: send key bytes (req_type 0), then message bytes (1), then a finish
// item (2). cfg_we_i/cfg_wdata_i set hmac_enable (1 = HMAC, 0 = plain
// SHA-256); write it only while the engine is idle. Both channels use
// valid/stall; a transfer happens when valid is high and stall is low.
// Each completed 64-byte block is compressed by the single round unit (16
// buffer reads, 64 rounds, one hash update). A key pad block is first
// copied from key memory. Finish pads the last block with one or two
// compressions, and in HMAC mode adds the outer hash (pad copy,
// compression, 8 digest words, padding, compression); then eight digest
// words leave at one per cycle while the output is not stalled.
// A rejected key byte gives one result with status 1 at once.
// Reset: hash words take the SHA-256 IV, the key is empty, hmac_enable is 1;
// no clearing pass is needed. A stalled output holds its word and the engine
// waits; no input is taken while a result is stalled.
// ----------------------------------------------------------------------------
module hmac_sha256_engine import hmac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        status_o,
  output logic        last_o
);

  st_e         st_q, st_d;
  ph_e         ph_q, ph_d;
  aft_e        aft_q, aft_d;
  fin_e        fin_q, fin_d;
  logic        hen_q;
  logic [6:0]  key_len_q, key_len_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic [7:0]  byte_q, byte_d;
  logic        is_fin_q, is_fin_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [7:0]  pad_q, pad_d;
  logic        mark_q, mark_d;

  logic [31:0] key_mem [16];
  logic [31:0] key_rd_q;
  logic [3:0]  kidx_q;
  logic        kv_q;
  logic [31:0] key_word;

  logic        key_we;
  logic [3:0]  key_addr;
  logic [3:0]  key_be;
  logic [31:0] key_wdata;

  blk_wr_t     blk_wr;
  hs_ctl_t     hs_ctl;
  hs_sts_t     hs_sts;
  logic [255:0] digest;
  logic [31:0] dig_sel;

  logic        in_xfer;
  logic        out_free;
  logic        out_load;
  logic [31:0] o_word;
  logic [2:0]  o_idx;
  logic        o_status, o_last;
  logic        out_vld_q;
  logic [31:0] out_word_q;
  logic [2:0]  out_idx_q;
  logic        out_status_q, out_last_q;

  hmac_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (blk_wr),
    .ctl_i    (hs_ctl),
    .sts_o    (hs_sts),
    .digest_o (digest)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_stall_o = !((st_q == S_IDLE) && out_free);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign dig_sel    = digest[{3'd7 - cnt_q[2:0], 5'd0} +: 32];

  // Key memory: byte writes, registered read
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      if (key_we && key_be[j]) key_mem[key_addr][8*j +: 8] <= key_wdata[8*j +: 8];
    end
    key_rd_q <= key_mem[cnt_q[3:0]];
    kidx_q   <= cnt_q[3:0];
  end

  // Bytes at or beyond the key length read as zero
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      key_word[31 - 8*j -: 8] = ({1'b0, kidx_q, 2'(j)} < key_len_q) ?
                                key_rd_q[31 - 8*j -: 8] : 8'h00;
    end
  end

  // Sequencer
  always_comb begin
    st_d      = st_q;
    ph_d      = ph_q;
    aft_d     = aft_q;
    fin_d     = fin_q;
    key_len_d = key_len_q;
    fill_d    = fill_q;
    len_d     = len_q;
    byte_d    = byte_q;
    is_fin_d  = is_fin_q;
    cnt_d     = cnt_q;
    pad_d     = pad_q;
    mark_d    = mark_q;
    hs_ctl    = '0;
    blk_wr.en   = 1'b0;
    blk_wr.addr = fill_q[5:2];
    blk_wr.be   = 4'b1000 >> fill_q[1:0];
    blk_wr.data = {4{byte_q}};
    key_we    = 1'b0;
    key_addr  = key_len_q[5:2];
    key_be    = 4'b1000 >> key_len_q[1:0];
    key_wdata = {4{data_byte_i}};
    out_load  = 1'b0;
    o_word    = '0;
    o_idx     = '0;
    o_status  = 1'b0;
    o_last    = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (in_xfer) begin
          byte_d   = data_byte_i;
          is_fin_d = (req_type_i == REQ_FIN);
          case (req_type_i) inside
            REQ_KEY: begin
              if (!hen_q || ph_q == PH_HMAC || ph_q == PH_PLAIN) begin
                // out-of-order key byte, or any key byte in plain mode
                out_load = 1'b1;
                o_status = 1'b1;
                o_last   = 1'b1;
              end else if (ph_q == PH_LONG) begin
                st_d = S_WRBYTE;
              end else if (key_len_q < 7'd64) begin
                key_we    = 1'b1;
                key_len_d = key_len_q + 7'd1;
                ph_d      = PH_KEY;
              end else begin
                // key overflows a block: hash it raw, then this byte
                ph_d  = PH_LONG;
                st_d  = S_KEYLD;
                cnt_d = '0;
                pad_d = NOPAD;
                aft_d = A_WRBYTE;
              end
            end
            REQ_MSG, REQ_FIN: begin
              if (ph_q == PH_IDLE || ph_q == PH_KEY || ph_q == PH_LONG) begin
                if (hen_q) begin
                  if (ph_q == PH_LONG) begin
                    st_d   = S_PAD;
                    mark_d = 1'b1;
                    fin_d  = F_LONGKEY;
                  end else begin
                    ph_d  = PH_HMAC;
                    st_d  = S_KEYLD;
                    cnt_d = '0;
                    pad_d = IPAD;
                    aft_d = A_REQ;
                  end
                end else begin
                  hs_ctl.init = 1'b1;
                  key_len_d   = '0;
                  fill_d      = '0;
                  len_d       = '0;
                  ph_d        = PH_PLAIN;
                  if (req_type_i == REQ_FIN) begin
                    st_d   = S_PAD;
                    mark_d = 1'b1;
                    fin_d  = F_DONE;
                  end else begin
                    st_d = S_WRBYTE;
                  end
                end
              end else if (req_type_i == REQ_FIN) begin
                st_d   = S_PAD;
                mark_d = 1'b1;
                fin_d  = (ph_q == PH_HMAC) ? F_INNER : F_DONE;
              end else begin
                st_d = S_WRBYTE;
              end
            end
            default: ;
          endcase
        end
      end
      S_KEYLD: begin
        if (kv_q) begin
          blk_wr.en   = 1'b1;
          blk_wr.addr = kidx_q;
          blk_wr.be   = 4'b1111;
          blk_wr.data = key_word ^ {4{pad_q}};
        end
        if (cnt_q == 5'd16) begin
          hs_ctl.start = 1'b1;
          len_d        = len_q + 64'd512;
          st_d         = S_HASH;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_WRBYTE: begin
        blk_wr.en = 1'b1;
        len_d     = len_q + 64'd8;
        if (fill_q == 6'd63) begin
          fill_d       = '0;
          hs_ctl.start = 1'b1;
          aft_d        = A_IDLE;
          st_d         = S_HASH;
        end else begin
          fill_d = fill_q + 6'd1;
          st_d   = S_IDLE;
        end
      end
      S_PAD: begin
        blk_wr.en   = 1'b1;
        blk_wr.data = {4{mark_q ? PAD_MARK : 8'h00}};
        mark_d      = 1'b0;
        if (fill_q == 6'd63) begin
          fill_d       = '0;
          hs_ctl.start = 1'b1;
          aft_d        = A_PAD;
          st_d         = S_HASH;
        end else if (fill_q == 6'd55) begin
          fill_d = 6'd56;
          cnt_d  = '0;
          st_d   = S_LEN;
        end else begin
          fill_d = fill_q + 6'd1;
        end
      end
      S_LEN: begin
        // 64-bit big-endian bit count in words 14 and 15
        blk_wr.en   = 1'b1;
        blk_wr.be   = 4'b1111;
        blk_wr.addr = cnt_q[0] ? 4'd15 : 4'd14;
        blk_wr.data = cnt_q[0] ? len_q[31:0] : len_q[63:32];
        if (cnt_q[0]) begin
          fill_d          = '0;
          hs_ctl.start    = 1'b1;
          hs_ctl.last_blk = 1'b1;
          aft_d           = A_FINAL;
          st_d            = S_HASH;
        end else begin
          cnt_d = 5'd1;
        end
      end
      S_HASH: begin
        if (hs_sts.done) begin
          cnt_d = '0;
          case (aft_q)
            A_IDLE:   st_d = S_IDLE;
            A_WRBYTE: st_d = S_WRBYTE;
            A_PAD:    st_d = S_PAD;
            A_DIGBLK: st_d = S_DIGBLK;
            A_REQ: begin
              if (is_fin_q) begin
                st_d   = S_PAD;
                mark_d = 1'b1;
                fin_d  = F_INNER;
              end else begin
                st_d = S_WRBYTE;
              end
            end
            default: begin
              len_d = '0;
              case (fin_q)
                F_LONGKEY: st_d = S_DIGKEY;
                F_INNER: begin
                  st_d  = S_KEYLD;
                  pad_d = OPAD;
                  aft_d = A_DIGBLK;
                end
                default: st_d = S_OUT;
              endcase
            end
          endcase
        end
      end
      S_DIGKEY: begin
        // hashed long key becomes the key block
        key_we    = 1'b1;
        key_addr  = {1'b0, cnt_q[2:0]};
        key_be    = 4'b1111;
        key_wdata = dig_sel;
        if (cnt_q[2:0] == 3'd7) begin
          key_len_d = 7'd32;
          ph_d      = PH_HMAC;
          st_d      = S_KEYLD;
          cnt_d     = '0;
          pad_d     = IPAD;
          aft_d     = A_REQ;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_DIGBLK: begin
        // inner digest follows the outer pad block
        blk_wr.en   = 1'b1;
        blk_wr.addr = {1'b0, cnt_q[2:0]};
        blk_wr.be   = 4'b1111;
        blk_wr.data = dig_sel;
        len_d       = len_q + 64'd32;
        if (cnt_q[2:0] == 3'd7) begin
          fill_d = 6'd32;
          st_d   = S_PAD;
          mark_d = 1'b1;
          fin_d  = F_DONE;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          o_word   = dig_sel;
          o_idx    = cnt_q[2:0];
          o_last   = (cnt_q[2:0] == 3'd7);
          if (cnt_q[2:0] == 3'd7) begin
            key_len_d = '0;
            ph_d      = PH_IDLE;
            st_d      = S_IDLE;
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      ph_q      <= PH_IDLE;
      aft_q     <= A_IDLE;
      fin_q     <= F_DONE;
      hen_q     <= 1'b1;
      key_len_q <= '0;
      fill_q    <= '0;
      len_q     <= '0;
      is_fin_q  <= 1'b0;
      cnt_q     <= '0;
      mark_q    <= 1'b0;
      kv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      ph_q      <= ph_d;
      aft_q     <= aft_d;
      fin_q     <= fin_d;
      if (cfg_we_i) hen_q <= cfg_wdata_i;
      key_len_q <= key_len_d;
      fill_q    <= fill_d;
      len_q     <= len_d;
      is_fin_q  <= is_fin_d;
      cnt_q     <= cnt_d;
      mark_q    <= mark_d;
      kv_q      <= (st_q == S_KEYLD) && (cnt_q < 5'd16);
      out_vld_q <= out_load || (out_vld_q && out_stall_i);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    pad_q  <= pad_d;
    if (out_load) begin
      out_word_q   <= o_word;
      out_idx_q    <= o_idx;
      out_status_q <= o_status;
      out_last_q   <= o_last;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign status_o      = out_status_q;
  assign last_o        = out_last_q;

  a_key_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_len_q <= 7'd64) else $error("key length overflow");

  a_reject_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_status_q |-> out_last_q && out_idx_q == 3'd0)
    else $error("reject result not a single item");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hs_ctl.start |-> !hs_sts.busy) else $error("compression started while busy");

  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hs_sts.busy |-> in_stall_o) else $error("input transfer during compression");

endmodule

FILE: rtl/core/hmac_core.sv
// ----------------------------------------------------------------------------
// hmac_core
// SHA-256 block compression: holds the 64-byte block buffer memory, the hash
// words, the working variables and a 16-word message schedule window.
// ----------------------------------------------------------------------------
module hmac_core import hmac_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  blk_wr_t        wr_i,
  input  hs_ctl_t        ctl_i,
  output hs_sts_t        sts_o,
  output logic [255:0]   digest_o
);

  cst_e        cst_q, cst_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        rdv_q;
  logic        last_q;
  logic [31:0] blk_mem [16];
  logic [31:0] rd_q;
  logic [31:0] sched_q [16];
  logic [31:0] wv_q [8];
  logic [31:0] hash_q [8];
  logic [255:0] dig_q;
  logic [31:0] t1, t2, wnew;
  logic [31:0] sum [8];

  // Block buffer: byte-lane writes, registered read
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      if (wr_i.en && wr_i.be[j]) begin
        blk_mem[wr_i.addr][8*j +: 8] <= wr_i.data[8*j +: 8];
      end
    end
    rd_q <= blk_mem[cnt_q[3:0]];
  end

  // Round and schedule datapath
  always_comb begin
    t1 = wv_q[7] + bsig1(wv_q[4]) + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
       + round_k(cnt_q) + sched_q[0];
    t2 = bsig0(wv_q[0]) + ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
    wnew = sched_q[0] + ssig0(sched_q[1]) + sched_q[9] + ssig1(sched_q[14]);
    for (int i = 0; i < 8; i++) begin
      sum[i] = hash_q[i] + wv_q[i];
    end
  end

  // Next state
  always_comb begin
    cst_d = cst_q;
    cnt_d = cnt_q;
    unique case (cst_q)
      C_IDLE: begin
        if (ctl_i.start) begin
          cst_d = C_LOAD;
          cnt_d = '0;
        end
      end
      C_LOAD: begin
        if (cnt_q == 6'd16) begin
          cst_d = C_ROUND;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      C_ROUND: begin
        if (cnt_q == 6'd63) cst_d = C_UPD;
        else cnt_d = cnt_q + 6'd1;
      end
      C_UPD: cst_d = C_IDLE;
      default: cst_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q <= C_IDLE;
      cnt_q <= '0;
      rdv_q <= 1'b0;
      last_q <= 1'b0;
      for (int i = 0; i < 8; i++) hash_q[i] <= SHA_IV[255 - 32*i -: 32];
    end else begin
      cst_q <= cst_d;
      cnt_q <= cnt_d;
      rdv_q <= (cst_q == C_LOAD) && (cnt_q < 6'd16);
      if (cst_q == C_IDLE && ctl_i.start) last_q <= ctl_i.last_blk;
      if (cst_q == C_IDLE && ctl_i.init) begin
        for (int i = 0; i < 8; i++) hash_q[i] <= SHA_IV[255 - 32*i -: 32];
      end else if (cst_q == C_UPD) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= last_q ? SHA_IV[255 - 32*i -: 32] : sum[i];
        end
      end
    end
  end

  // Working variables, schedule window and digest capture (final block only)
  always_ff @(posedge clk_i) begin
    if (cst_q == C_IDLE && ctl_i.start) begin
      for (int i = 0; i < 8; i++) wv_q[i] <= hash_q[i];
    end
    if (rdv_q || cst_q == C_ROUND) begin
      for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i+1];
      sched_q[15] <= rdv_q ? rd_q : wnew;
    end
    if (cst_q == C_ROUND) begin
      wv_q[7] <= wv_q[6];
      wv_q[6] <= wv_q[5];
      wv_q[5] <= wv_q[4];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[3] <= wv_q[2];
      wv_q[2] <= wv_q[1];
      wv_q[1] <= wv_q[0];
      wv_q[0] <= t1 + t2;
    end
    if (cst_q == C_UPD && last_q) begin
      for (int i = 0; i < 8; i++) dig_q[255 - 32*i -: 32] <= sum[i];
    end
  end

  assign sts_o.busy = (cst_q != C_IDLE);
  assign sts_o.done = (cst_q == C_UPD);
  assign digest_o   = dig_q;

  // Block buffer must not change while a block is being hashed
  a_no_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |-> cst_q == C_IDLE) else $error("block write during compression");

  a_start_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> cst_q == C_IDLE) else $error("start while compressing");

  a_no_load_in_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cst_q == C_ROUND |-> !rdv_q) else $error("buffer read overlaps rounds");

  a_upd_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cst_q == C_UPD |=> cst_q == C_IDLE) else $error("hash update not single cycle");

endmodule

FILE: dv/hmac_sha256_engine_tb.sv
// ----------------------------------------------------------------------------
// hmac_sha256_engine_tb
// Self-checking bench for the HMAC-SHA256 / SHA-256 streaming engine. Key,
// message and finish transfers go through a clocked driver, and an internal
// SHA-256 predictor builds the expected digest words. A monitor then checks
// every output transfer against the oldest expected word. The run covers
// both modes, long keys and padding boundaries under random flow control.
// ----------------------------------------------------------------------------
module hmac_sha256_engine_tb import hmac_pkg::*; ();

  localparam logic [1:0] REQ_NONE = 2'd3;  // unused code, engine drops it
  localparam int TAIL_CYCLES = 300;        // covers a long-key block hash
  localparam int STALL_LIMIT = 4000;       // cycles without any transfer

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        status;
    logic        last;
  } digest_t;

  typedef enum {OP_ITEM, OP_CFG, OP_DRAIN, OP_IDLE} op_e;

  typedef struct {
    op_e        op;
    logic [1:0] req;
    logic [7:0] data;
    int         snd;
    int         rcv;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = REQ_KEY;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        status_o;
  logic        last_o;

  hmac_sha256_engine u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .req_type_i,
    .data_byte_i,
    .out_valid_o,
    .out_stall_i,
    .digest_word_o,
    .word_index_o,
    .status_o,
    .last_o
  );

  always #6 clk_i = ~clk_i;

  // Predictor state
  logic [31:0] hv [8];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [63:0] tbits;
  logic [7:0]  kst [64];
  int unsigned kfill;
  bit          klong;
  ph_e         ph;
  bit          hmac_en;

  digest_t     digest_q [$];
  stim_t       stim_q [$];
  int          errs = 0;
  int          snd_idle = 0;
  int          rcv_idle = 0;
  int          hold_cnt = 0;
  bit          stim_done = 1'b0;
  bit          in_acc = 1'b0;
  int          quiet_cnt = 0;
  int          item_cnt = 0;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int s);
    return (x >> s) | (x << (32 - s));
  endfunction

  // One SHA-256 block over blk[] into hv[]
  function automatic void sha_compress();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2, x15, x2;
    for (int i = 0; i < 8; i++) v[i] = hv[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wt = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      end else begin
        x15 = w[(r-15) & 15];
        x2  = w[(r-2) & 15];
        wt = w[r & 15] + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) + w[(r-7) & 15]
             + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
      end
      w[r & 15] = wt;
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + wt;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] += v[i];
  endfunction

  function automatic void sha_init();
    for (int i = 0; i < 8; i++) hv[i] = SHA_IV[255-32*i -: 32];
    fill = 0;
    tbits = '0;
  endfunction

  function automatic void sha_byte(input logic [7:0] b);
    blk[fill] = b;
    fill++;
    if (fill == 64) begin
      sha_compress();
      tbits += 64'd512;
      fill = 0;
    end
  endfunction

  // Pad, append the bit count, return the digest with word 0 on top
  function automatic logic [255:0] sha_final();
    logic [255:0] d;
    logic [63:0]  bits;
    bits = tbits + 64'(fill) * 64'd8;
    blk[fill] = PAD_MARK;
    fill++;
    if (fill > 56) begin
      while (fill < 64) begin blk[fill] = 8'h00; fill++; end
      sha_compress();
      fill = 0;
    end
    while (fill < 56) begin blk[fill] = 8'h00; fill++; end
    for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
    sha_compress();
    for (int i = 0; i < 8; i++) d[255-32*i -: 32] = hv[i];
    sha_init();
    return d;
  endfunction

  function automatic void feed_key_pad(input logic [7:0] pad);
    for (int i = 0; i < 64; i++) sha_byte(kst[i] ^ pad);
  endfunction

  function automatic void clear_key();
    for (int i = 0; i < 64; i++) kst[i] = 8'h00;
    kfill = 0;
    klong = 1'b0;
  endfunction

  function automatic void engine_reset();
    hmac_en = 1'b1;
    sha_init();
    clear_key();
    ph = PH_IDLE;
  endfunction

  // Advance the predictor by one accepted transfer
  function automatic void digest_predict(input logic [1:0] req, input logic [7:0] b);
    logic [255:0] d;
    if (req == REQ_KEY) begin
      if (!hmac_en || ph >= PH_HMAC) begin
        digest_q.push_back('{word: 32'h0, idx: 3'd0, status: 1'b1, last: 1'b1});
      end else if (ph == PH_LONG) begin
        sha_byte(b);
      end else if (kfill < 64) begin
        kst[kfill] = b;
        kfill++;
        ph = PH_KEY;
      end else begin
        // key overflows one block: hash it from here on
        sha_init();
        for (int i = 0; i < 64; i++) sha_byte(kst[i]);
        sha_byte(b);
        klong = 1'b1;
        ph = PH_LONG;
      end
      return;
    end
    if (req == REQ_NONE) return;
    // first message byte or finish opens the message part
    if (ph < PH_HMAC) begin
      if (hmac_en) begin
        if (klong) begin
          d = sha_final();
          for (int i = 0; i < 64; i++) kst[i] = (i < 32) ? d[255-8*i -: 8] : 8'h00;
        end
        sha_init();
        feed_key_pad(IPAD);
        ph = PH_HMAC;
      end else begin
        clear_key();
        sha_init();
        ph = PH_PLAIN;
      end
    end
    if (req == REQ_MSG) begin
      sha_byte(b);
      return;
    end
    d = sha_final();
    if (ph == PH_HMAC) begin
      feed_key_pad(OPAD);
      for (int i = 0; i < 32; i++) sha_byte(d[255-8*i -: 8]);
      d = sha_final();
    end
    for (int i = 0; i < 8; i++)
      digest_q.push_back('{word: d[255-32*i -: 32], idx: 3'(i), status: 1'b0,
                           last: (i == 7)});
    clear_key();
    sha_init();
    ph = PH_IDLE;
  endfunction

  // Stimulus builders
  function automatic void put_item(input logic [1:0] req, input logic [7:0] b);
    stim_q.push_back('{op: OP_ITEM, req: req, data: b, snd: 0, rcv: 0});
    item_cnt++;
  endfunction

  function automatic void put_cfg(input logic en);
    stim_q.push_back('{op: OP_DRAIN, req: REQ_KEY, data: 8'h00, snd: 0, rcv: 0});
    stim_q.push_back('{op: OP_CFG, req: REQ_KEY, data: {7'h0, en}, snd: 0, rcv: 0});
  endfunction

  function automatic void put_idle(input int s, input int r);
    stim_q.push_back('{op: OP_IDLE, req: REQ_KEY, data: 8'h00, snd: s, rcv: r});
  endfunction

  // One transaction with random content and occasional noise
  function automatic void put_txn(input int klen, input int mlen);
    for (int i = 0; i < klen; i++) put_item(REQ_KEY, 8'($urandom));
    for (int i = 0; i < mlen; i++) begin
      put_item(REQ_MSG, 8'($urandom));
      if ($urandom_range(99) < 3) put_item(REQ_KEY, 8'($urandom));
      if ($urandom_range(99) < 3) put_item(REQ_NONE, 8'($urandom));
    end
    put_item(REQ_FIN, 8'($urandom));
  endfunction

  function automatic int pick_len();
    int p;
    p = $urandom_range(99);
    if (p < 10) return $urandom_range(70, 55);
    if (p < 14) return $urandom_range(100, 64);
    return $urandom_range(20);
  endfunction

  // Driver: new inputs at the falling edge
  always @(negedge clk_i) begin
    logic       nv, nwe, nwd;
    logic [1:0] nreq;
    logic [7:0] ndat;
    nv = in_valid_i;
    nreq = req_type_i;
    ndat = data_byte_i;
    nwe = 1'b0;
    nwd = cfg_wdata_i;
    if (rst_ni && !(in_valid_i && !in_acc)) begin
      nv = 1'b0;
      if (hold_cnt != 0) begin
        hold_cnt--;
      end else if (stim_q.size() != 0) begin
        case (stim_q[0].op)
          OP_ITEM: begin
            if ($urandom_range(99) >= snd_idle) begin
              nv = 1'b1;
              nreq = stim_q[0].req;
              ndat = stim_q[0].data;
              void'(stim_q.pop_front());
            end
          end
          OP_CFG: begin
            nwe = 1'b1;
            nwd = stim_q[0].data[0];
            void'(stim_q.pop_front());
          end
          OP_DRAIN: begin
            if (digest_q.size() == 0) begin
              hold_cnt = TAIL_CYCLES;
              void'(stim_q.pop_front());
            end
          end
          default: begin
            snd_idle = stim_q[0].snd;
            rcv_idle = stim_q[0].rcv;
            void'(stim_q.pop_front());
          end
        endcase
      end else begin
        stim_done = 1'b1;
      end
    end
    in_valid_i  <= nv;
    req_type_i  <= nreq;
    data_byte_i <= ndat;
    cfg_we_i    <= nwe;
    cfg_wdata_i <= nwd;
    out_stall_i <= rst_ni && ($urandom_range(99) < rcv_idle);
  end

  // Monitor: sample transfers at the rising edge, predict and check
  always @(posedge clk_i) begin
    digest_t e;
    bit      busy;
    busy = 1'b0;
    in_acc <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (cfg_we_i) begin
        hmac_en = cfg_wdata_i;
        busy = 1'b1;
      end
      if (in_valid_i && !in_stall_o) begin
        digest_predict(req_type_i, data_byte_i);
        busy = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        busy = 1'b1;
        if (digest_q.size() == 0) begin
          $error("unexpected result transfer: word %h index %0d", digest_word_o,
                 word_index_o);
          errs++;
        end else begin
          e = digest_q.pop_front();
          if (digest_word_o !== e.word) begin
            $error("digest_word exp %h got %h", e.word, digest_word_o);
            errs++;
          end
          if (word_index_o !== e.idx) begin
            $error("word_index exp %0d got %0d", e.idx, word_index_o);
            errs++;
          end
          if (status_o !== e.status) begin
            $error("status exp %0d got %0d", e.status, status_o);
            errs++;
          end
          if (last_o !== e.last) begin
            $error("last exp %0d got %0d", e.last, last_o);
            errs++;
          end
        end
      end
      quiet_cnt = busy ? 0 : quiet_cnt + 1;
      if (quiet_cnt >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int phase_start;
    engine_reset();

    // Directed: byte extremes, rejected keys, dropped code, empty transaction
    put_item(REQ_KEY, 8'h00);
    put_item(REQ_KEY, 8'hff);
    put_item(REQ_MSG, 8'h00);
    put_item(REQ_NONE, 8'hff);
    put_item(REQ_MSG, 8'hff);
    put_item(REQ_MSG, 8'h80);
    put_item(REQ_KEY, 8'haa);  // key after message start
    put_item(REQ_FIN, 8'h00);
    put_item(REQ_FIN, 8'hff);  // empty key and empty message
    put_cfg(1'b0);
    put_item(REQ_KEY, 8'h01);  // key in plain mode
    put_item(REQ_MSG, 8'h5a);
    put_item(REQ_FIN, 8'h00);
    put_item(REQ_FIN, 8'h00);
    put_cfg(1'b1);
    put_txn(64, 55);           // full key block, message that just fits
    put_txn(65, 0);            // key turns long, empty message

    // Random: three flow-control settings, mode set at random between transactions
    put_idle(31, 66);
    for (int p = 0; p < 3; p++) begin
      if (p == 1) put_idle(66, 31);
      if (p == 2) put_idle(0, 0);
      phase_start = item_cnt;
      while (item_cnt - phase_start < 25) begin
        if ($urandom_range(99) < 25) put_cfg(1'($urandom));
        put_txn(pick_len(), pick_len());
      end
      put_cfg(1'b1);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!stim_done || digest_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errs == 0 && digest_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/hmac_pkg.sv
rtl/core/hmac_core.sv
rtl/core/hmac_sha256_engine.sv
dv/hmac_sha256_engine_tb.sv
